[rtl/cbmq_pkg.sv]
// ----------------------------------------------------------------------------
// cbmq_pkg
// Types and constants shared by the coalescing bounded motion queue.
// ----------------------------------------------------------------------------
package cbmq_pkg;

	localparam int DEPTH = 16;
	localparam int PTR_W = $clog2(DEPTH);
	localparam int CNT_W = $clog2(DEPTH + 1);
	localparam int CAP_W = 5;
	localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(DEPTH);

	typedef enum logic [1:0] {
		CMD_ENQUEUE = 2'd0,
		CMD_REQUEUE = 2'd1,
		CMD_POP     = 2'd2,
		CMD_PEEK    = 2'd3
	} command_t;

	typedef struct packed {
		command_t    command;
		logic [31:0] target_id;
		logic [31:0] motion_x;
		logic [31:0] motion_y;
		logic [63:0] motion_time;
	} cmd_word_t;

	typedef struct packed {
		logic        status;
		logic        merged;
		logic        dropped;
		logic [31:0] head_id;
		logic [31:0] head_x;
		logic [31:0] head_y;
		logic [63:0] head_time;
		logic [4:0]  count;
		logic        is_empty;
	} rsp_word_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_MATCH,
		ST_EXEC
	} state_t;

	typedef struct packed {
		logic capture;
		logic compare;
		logic execute;
	} ctl_t;

	typedef struct packed {
		logic rsp_free;
	} sts_t;

endpackage

[rtl/cbmq_ctrl.sv]
// ----------------------------------------------------------------------------
// cbmq_ctrl
// Sequencer: capture a word, register the id compare, then update the queue.
// ----------------------------------------------------------------------------
module cbmq_ctrl import cbmq_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic cmd_valid,
	output logic cmd_stall,
	input  sts_t sts,
	output ctl_t ctl
);

	state_t state_q;
	state_t state_nxt;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	always_comb begin
		state_nxt = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (cmd_valid) begin
					state_nxt = ST_MATCH;
				end
			end
			ST_MATCH: begin
				state_nxt = ST_EXEC;
			end
			ST_EXEC: begin
				if (sts.rsp_free) begin
					state_nxt = ST_IDLE;
				end
			end
			default: begin
				state_nxt = ST_IDLE;
			end
		endcase
	end

	always_comb begin
		cmd_stall   = (state_q != ST_IDLE);
		ctl.capture = (state_q == ST_IDLE) && cmd_valid;
		ctl.compare = (state_q == ST_MATCH);
		ctl.execute = (state_q == ST_EXEC) && sts.rsp_free;
	end

endmodule

[rtl/cbmq_datapath.sv]
// ----------------------------------------------------------------------------
// cbmq_datapath
// Entry store, id compare, ring pointers, capacity register and result word.
// ----------------------------------------------------------------------------
module cbmq_datapath import cbmq_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  ctl_t       ctl,
	output sts_t       sts,
	input  cmd_word_t  cmd_word,
	input  logic       cfg_valid,
	input  logic [4:0] cfg_word,
	output logic       rsp_valid,
	input  logic       rsp_stall,
	output rsp_word_t  rsp_word
);

	cmd_word_t        item_q;
	logic [DEPTH-1:0] match_s1;
	logic [31:0]      ids_q   [DEPTH];
	logic [31:0]      xs_q    [DEPTH];
	logic [31:0]      ys_q    [DEPTH];
	logic [63:0]      times_q [DEPTH];
	logic [PTR_W-1:0] head_q;
	logic [CNT_W-1:0] count_q;
	logic [CAP_W-1:0] cap_q;
	logic             rsp_valid_q;
	rsp_word_t        rsp_q;

	logic [CNT_W-1:0] cap_lim;
	logic             full;
	logic [DEPTH-1:0] match_rot;
	logic             hit;
	logic [PTR_W-1:0] hit_off;
	logic [PTR_W-1:0] head_nxt;
	logic [CNT_W-1:0] count_nxt;
	logic             wr_en;
	logic             wr_id;
	logic [PTR_W-1:0] wr_slot;
	rsp_word_t        rsp_nxt;

	// live-slot id compare, registered
	always_ff @(posedge clk) begin
		if (ctl.capture) begin
			item_q <= cmd_word;
		end
		if (ctl.compare) begin
			for (int s = 0; s < DEPTH; s++) begin
				match_s1[s] <= ({1'b0, PTR_W'(s) - head_q} < count_q) &&
					(ids_q[s] == item_q.target_id);
			end
		end
		if (ctl.execute) begin
			rsp_q <= rsp_nxt;
			if (wr_en) begin
				xs_q[wr_slot]    <= item_q.motion_x;
				ys_q[wr_slot]    <= item_q.motion_y;
				times_q[wr_slot] <= item_q.motion_time;
				if (wr_id) begin
					ids_q[wr_slot] <= item_q.target_id;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q      <= '0;
			count_q     <= '0;
			cap_q       <= CAP_RESET;
			rsp_valid_q <= 1'b0;
		end else begin
			if (cfg_valid) begin
				cap_q <= cfg_word;
			end
			if (ctl.execute) begin
				head_q      <= head_nxt;
				count_q     <= count_nxt;
				rsp_valid_q <= 1'b1;
			end else if (!rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	// the match taken is the one at the highest offset from the head
	always_comb begin
		hit_off = '0;
		for (int o = 0; o < DEPTH; o++) begin
			match_rot[o] = match_s1[head_q + PTR_W'(o)];
		end
		for (int o = 0; o < DEPTH; o++) begin
			if (match_rot[o]) begin
				hit_off = PTR_W'(o);
			end
		end
		hit = |match_s1;
	end

	always_comb begin
		if (cap_q == '0) begin
			cap_lim = CNT_W'(1);
		end else if (CNT_W'(cap_q) > CNT_W'(DEPTH)) begin
			cap_lim = CNT_W'(DEPTH);
		end else begin
			cap_lim = CNT_W'(cap_q);
		end
		full = (count_q >= cap_lim) && (count_q != '0);

		head_nxt  = head_q;
		count_nxt = count_q;
		wr_en     = 1'b0;
		wr_id     = 1'b0;
		wr_slot   = head_q + count_q[PTR_W-1:0];
		rsp_nxt   = '0;

		unique case (item_q.command)
			CMD_ENQUEUE: begin
				wr_en = 1'b1;
				if (hit) begin
					wr_slot        = head_q + hit_off;
					rsp_nxt.merged = 1'b1;
				end else begin
					wr_id = 1'b1;
					if (full) begin
						head_nxt        = head_q + PTR_W'(1);
						rsp_nxt.dropped = 1'b1;
					end else begin
						count_nxt = count_q + CNT_W'(1);
					end
				end
			end
			CMD_REQUEUE: begin
				wr_en    = 1'b1;
				wr_id    = 1'b1;
				head_nxt = head_q - PTR_W'(1);
				wr_slot  = head_nxt;
				if (full) begin
					rsp_nxt.dropped = 1'b1;
				end else begin
					count_nxt = count_q + CNT_W'(1);
				end
			end
			CMD_POP, CMD_PEEK: begin
				if (count_q == '0) begin
					rsp_nxt.status = 1'b1;
				end else begin
					rsp_nxt.head_id   = ids_q[head_q];
					rsp_nxt.head_x    = xs_q[head_q];
					rsp_nxt.head_y    = ys_q[head_q];
					rsp_nxt.head_time = times_q[head_q];
					if (item_q.command == CMD_POP) begin
						head_nxt  = head_q + PTR_W'(1);
						count_nxt = count_q - CNT_W'(1);
					end
				end
			end
			default: begin
				rsp_nxt.status = 1'b1;
			end
		endcase

		rsp_nxt.count    = 5'(count_nxt);
		rsp_nxt.is_empty = (count_nxt == '0);
	end

	assign sts.rsp_free = !rsp_valid_q || !rsp_stall;
	assign rsp_valid    = rsp_valid_q;
	assign rsp_word     = rsp_q;

endmodule

[rtl/coalescing_bounded_motion_queue.sv]
// ----------------------------------------------------------------------------
// coalescing_bounded_motion_queue
// Bounded deque of motion records with id coalescing on enqueue.
//
//   channel  dir  handshake             word
//   cmd      in   cmd_valid/cmd_stall   cmd_word_t
//   rsp      out  rsp_valid/rsp_stall   rsp_word_t
//   cfg      in   cfg_valid/cfg_ready   capacity, 5 bits
//
// Each word passes capture, a registered id compare over all slots,
// then queue update with the result loaded into the output register.
// The update waits while a previous result is held by rsp_stall; a new
// word is taken while a finished result is still waiting.
// Reset: empty queue, capacity 16, no clearing pass; cfg_ready is always high.
// ----------------------------------------------------------------------------
module coalescing_bounded_motion_queue import cbmq_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       cmd_valid,
	output logic       cmd_stall,
	input  cmd_word_t  cmd_word,
	output logic       rsp_valid,
	input  logic       rsp_stall,
	output rsp_word_t  rsp_word,
	input  logic       cfg_valid,
	output logic       cfg_ready,
	input  logic [4:0] cfg_word
);

	ctl_t ctl;
	sts_t sts;

	assign cfg_ready = 1'b1;

	cbmq_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (cmd_valid),
		.cmd_stall (cmd_stall),
		.sts       (sts),
		.ctl       (ctl)
	);

	cbmq_datapath u_datapath (
		.clk       (clk),
		.arst_n    (arst_n),
		.ctl       (ctl),
		.sts       (sts),
		.cmd_word  (cmd_word),
		.cfg_valid (cfg_valid),
		.cfg_word  (cfg_word),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp_word  (rsp_word)
	);

endmodule

[rtl/cbmq_checker.sv]
// ----------------------------------------------------------------------------
// cbmq_checker
// Port-level checks on the motion queue, bound to the top level.
// ----------------------------------------------------------------------------
module cbmq_checker import cbmq_pkg::*; (
	input logic       clk,
	input logic       arst_n,
	input logic       cmd_valid,
	input logic       cmd_stall,
	input logic       rsp_valid,
	input logic       rsp_stall,
	input rsp_word_t  rsp_word
);

	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_word))
		else $error("result word changed while stalled");

	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		cmd_valid && !cmd_stall |=> cmd_stall)
		else $error("second word taken while one is in flight");

	a_empty_flag: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> (rsp_word.is_empty == (rsp_word.count == '0)))
		else $error("empty flag disagrees with count");

	a_error_clean: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_word.status |->
			!rsp_word.merged && !rsp_word.dropped && rsp_word.is_empty)
		else $error("error result with merge, drop or entries");

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> (rsp_word.count <= 5'(DEPTH)))
		else $error("count above depth");

endmodule

bind coalescing_bounded_motion_queue cbmq_checker u_cbmq_checker (.*);

[dv/tb_top.sv]
// ----------------------------------------------------------------------------
// tb_top
// Testbench for the coalescing bounded motion queue. A clocked driver feeds
// command words from a backlog filled by the stimulus sequence; a clocked
// monitor checks every result word against a behavioural copy of the queue,
// field by field. Directed words cover empty pops and peeks, id merging,
// drops on a full queue at both ends, a capacity lowered below the count and
// a capacity of zero; random phases then sweep the capacity register with
// random gaps on both sides, one phase without gaps and one long result hold-off.
// ----------------------------------------------------------------------------
module tb_top;
	import cbmq_pkg::*;

	localparam int HOLD_LEN       = 300;
	localparam int WATCHDOG_LIMIT = 3000;
	localparam int PHASE_WORDS    = 50;
	localparam int BACKLOG_LEN    = 1024;

	logic       clk;
	logic       arst_n;
	logic       cmd_valid = 1'b0;
	logic       cmd_stall;
	cmd_word_t  cmd_word  = '0;
	logic       rsp_valid;
	logic       rsp_stall = 1'b0;
	rsp_word_t  rsp_word;
	logic       cfg_valid = 1'b0;
	logic       cfg_ready;
	logic [4:0] cfg_word  = '0;

	coalescing_bounded_motion_queue u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (cmd_valid),
		.cmd_stall (cmd_stall),
		.cmd_word  (cmd_word),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp_word  (rsp_word),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_word  (cfg_word)
	);

	cmd_word_t cmd_backlog  [BACKLOG_LEN];
	int        backlog_wr   = 0;
	int        backlog_rd   = 0;
	rsp_word_t rsp_expected [BACKLOG_LEN];
	int        expect_wr    = 0;
	int        expect_rd    = 0;
	int        mismatches  = 0;
	int        cmd_gap_pct = 10;
	int        rsp_gap_pct = 10;
	bit        hold_armed  = 1'b0;
	int        hold_cycles = 0;

	// queue copy
	logic [31:0]      q_id   [DEPTH];
	logic [31:0]      q_x    [DEPTH];
	logic [31:0]      q_y    [DEPTH];
	logic [63:0]      q_time [DEPTH];
	logic [PTR_W-1:0] q_head  = '0;
	int               q_count = 0;
	logic [4:0]       cap_reg = CAP_RESET;

	initial begin
		clk    = 1'b0;
		arst_n = 1'b0;
		repeat (6) #1 clk = ~clk;
		arst_n = 1'b1;
		forever #1 clk = ~clk;
	end

	function automatic rsp_word_t motion_queue_apply(cmd_word_t w);
		rsp_word_t        r;
		int               lim;
		int               i;
		bit               hit;
		logic [PTR_W-1:0] s;
		r   = '0;
		lim = cap_reg;
		if (lim == 0)
			lim = 1;
		if (lim > DEPTH)
			lim = DEPTH;
		case (w.command)
			CMD_ENQUEUE: begin
				hit = 1'b0;
				for (i = q_count - 1; i >= 0 && !hit; i--) begin
					s = q_head + PTR_W'(i);
					if (q_id[s] == w.target_id) begin
						q_x[s]    = w.motion_x;
						q_y[s]    = w.motion_y;
						q_time[s] = w.motion_time;
						hit       = 1'b1;
					end
				end
				if (hit) begin
					r.merged = 1'b1;
				end else begin
					if (q_count >= lim && q_count > 0) begin
						q_head++;
						q_count--;
						r.dropped = 1'b1;
					end
					s         = q_head + PTR_W'(q_count);
					q_id[s]   = w.target_id;
					q_x[s]    = w.motion_x;
					q_y[s]    = w.motion_y;
					q_time[s] = w.motion_time;
					q_count++;
				end
			end
			CMD_REQUEUE: begin
				if (q_count >= lim && q_count > 0) begin
					q_count--;
					r.dropped = 1'b1;
				end
				q_head--;
				q_id[q_head]   = w.target_id;
				q_x[q_head]    = w.motion_x;
				q_y[q_head]    = w.motion_y;
				q_time[q_head] = w.motion_time;
				q_count++;
			end
			default: begin
				if (q_count == 0) begin
					r.status = 1'b1;
				end else begin
					r.head_id   = q_id[q_head];
					r.head_x    = q_x[q_head];
					r.head_y    = q_y[q_head];
					r.head_time = q_time[q_head];
					if (w.command == CMD_POP) begin
						q_head++;
						q_count--;
					end
				end
			end
		endcase
		r.count    = 5'(q_count);
		r.is_empty = (q_count == 0);
		return r;
	endfunction

	function automatic void check_field(string name, logic [63:0] want, logic [63:0] got);
		if (want !== got) begin
			mismatches++;
			$display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
		end
	endfunction

	task automatic check_result(rsp_word_t got);
		rsp_word_t want;
		if (expect_rd == expect_wr) begin
			mismatches++;
			$display("%0t: result word with none expected, expected none, actual %h",
				$time, got);
		end else begin
			want = rsp_expected[expect_rd];
			expect_rd++;
			check_field("status", want.status, got.status);
			check_field("merged", want.merged, got.merged);
			check_field("dropped", want.dropped, got.dropped);
			check_field("head_id", want.head_id, got.head_id);
			check_field("head_x", want.head_x, got.head_x);
			check_field("head_y", want.head_y, got.head_y);
			check_field("head_time", want.head_time, got.head_time);
			check_field("count", want.count, got.count);
			check_field("is_empty", want.is_empty, got.is_empty);
		end
	endtask

	// command driver
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cmd_valid <= 1'b0;
		end else begin
			if (cmd_valid && !cmd_stall) begin
				rsp_expected[expect_wr] = motion_queue_apply(cmd_word);
				expect_wr++;
			end
			if (!cmd_valid || !cmd_stall) begin
				if (backlog_rd != backlog_wr && $urandom_range(99) >= cmd_gap_pct) begin
					cmd_valid <= 1'b1;
					cmd_word  <= cmd_backlog[backlog_rd];
					backlog_rd++;
				end else begin
					cmd_valid <= 1'b0;
				end
			end
		end
	end

	// result monitor
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_stall <= 1'b0;
		end else begin
			if (rsp_valid && !rsp_stall)
				check_result(rsp_word);
			if (hold_armed && hold_cycles < HOLD_LEN) begin
				rsp_stall   <= 1'b1;
				hold_cycles <= hold_cycles + 1;
			end else begin
				rsp_stall <= ($urandom_range(99) < rsp_gap_pct);
			end
		end
	end

	initial begin
		int quiet_cycles;
		quiet_cycles = 0;
		while (quiet_cycles < WATCHDOG_LIMIT) begin
			@(posedge clk);
			if ((cmd_valid && !cmd_stall) || (rsp_valid && !rsp_stall) ||
				(cfg_valid && cfg_ready))
				quiet_cycles = 0;
			else
				quiet_cycles++;
		end
		$display("Testbench completed WITH ERRORS");
		$finish;
	end

	task automatic push_word(command_t c, logic [31:0] id, logic [31:0] x,
		logic [31:0] y, logic [63:0] t);
		cmd_word_t w;
		w.command     = c;
		w.target_id   = id;
		w.motion_x    = x;
		w.motion_y    = y;
		w.motion_time = t;
		cmd_backlog[backlog_wr] = w;
		backlog_wr++;
	endtask

	task automatic push_random_word(int enq_w);
		int          p;
		int          k;
		command_t    c;
		logic [31:0] id;
		p = $urandom_range(99);
		if (p < enq_w)
			c = CMD_ENQUEUE;
		else if (p < enq_w + 15)
			c = CMD_REQUEUE;
		else if (p < enq_w + 15 + (85 - enq_w) * 2 / 3)
			c = CMD_POP;
		else
			c = CMD_PEEK;
		// small id pool so that merges are frequent
		k = $urandom_range(9);
		if (k <= 5)
			id = 32'(k);
		else if (k == 6)
			id = 32'hFFFF_FFFF;
		else
			id = $urandom;
		push_word(c, id, $urandom, $urandom, {$urandom, $urandom});
	endtask

	task automatic wait_drained();
		do
			@(negedge clk);
		while (backlog_rd != backlog_wr || cmd_valid || expect_rd != expect_wr);
	endtask

	task automatic write_capacity(logic [4:0] v);
		@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_word  <= v;
		do
			@(posedge clk);
		while (!cfg_ready);
		cap_reg = v;
		cfg_valid <= 1'b0;
		@(negedge clk);
	endtask

	initial begin
		logic [4:0] caps[8];
		int         k;
		int         n;
		caps = '{5'd16, 5'd31, 5'd1, 5'd3, 5'd17, 5'd8, 5'd0, 5'd16};
		wait (arst_n === 1'b1);
		@(negedge clk);

		// empty queue, merging, extremes of the fields
		push_word(CMD_POP, 32'h0, 32'h0, 32'h0, 64'h0);
		push_word(CMD_PEEK, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, '1);
		push_word(CMD_ENQUEUE, 32'h0, 32'h0, 32'h0, 64'h0);
		push_word(CMD_ENQUEUE, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, '1);
		push_word(CMD_ENQUEUE, 32'h0, 32'h1234_5678, 32'h8765_4321, 64'hDEAD_BEEF_0BAD_F00D);
		push_word(CMD_PEEK, 32'h0, 32'h0, 32'h0, 64'h0);
		push_word(CMD_REQUEUE, 32'h7, 32'hA5A5_A5A5, 32'h5A5A_5A5A, 64'h8000_0000_0000_0001);
		push_word(CMD_POP, 32'h0, 32'h0, 32'h0, 64'h0);
		push_word(CMD_PEEK, 32'h0, 32'h0, 32'h0, 64'h0);
		for (k = 10; k < 15; k++)
			push_word(CMD_ENQUEUE, 32'(k), $urandom, $urandom, {$urandom, $urandom});
		wait_drained();

		// capacity below the current count
		write_capacity(5'd2);
		push_word(CMD_ENQUEUE, 32'd20, $urandom, $urandom, {$urandom, $urandom});
		push_word(CMD_REQUEUE, 32'd21, $urandom, $urandom, {$urandom, $urandom});
		push_word(CMD_ENQUEUE, 32'd12, $urandom, $urandom, {$urandom, $urandom});
		push_word(CMD_PEEK, 32'h0, 32'h0, 32'h0, 64'h0);
		wait_drained();

		// capacity zero behaves as one
		write_capacity(5'd0);
		push_word(CMD_ENQUEUE, 32'd30, $urandom, $urandom, {$urandom, $urandom});
		push_word(CMD_REQUEUE, 32'd31, $urandom, $urandom, {$urandom, $urandom});
		push_word(CMD_POP, 32'h0, 32'h0, 32'h0, 64'h0);
		push_word(CMD_POP, 32'h0, 32'h0, 32'h0, 64'h0);
		wait_drained();

		for (k = 0; k < 8; k++) begin
			write_capacity(caps[k]);
			cmd_gap_pct = (k == 4) ? 0 : 10;
			rsp_gap_pct = (k == 4) ? 0 : 10;
			if (k == 1)
				hold_armed = 1'b1;
			for (n = 0; n < PHASE_WORDS; n++)
				push_random_word((k % 2 == 0) ? 55 : 30);
			wait_drained();
		end

		repeat (10) @(posedge clk);
		if (mismatches == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule

[sim.f]
rtl/cbmq_pkg.sv
rtl/cbmq_ctrl.sv
rtl/cbmq_datapath.sv
rtl/coalescing_bounded_motion_queue.sv
rtl/cbmq_checker.sv
dv/tb_top.sv
